### rtl/tfpt_pkg.sv
// Shared types and constants for the tuner frequency preset table.
package tfpt_pkg;

    localparam int PRESETS = 64;
    localparam int IDX_W = $clog2(PRESETS);
    localparam int CNT_W = $clog2(PRESETS + 1);

    localparam logic [15:0] SPLIT_FREQ = 16'd7600;
    localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

    localparam logic [15:0] BAND_MIN_RST = 16'd8750;
    localparam logic [15:0] BAND_MAX_RST = 16'd10800;
    localparam logic [7:0] STEP_RST = 8'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_BAND_MIN = 2'd0;
    localparam logic [1:0] REG_BAND_MAX = 2'd1;
    localparam logic [1:0] REG_STEP_LOW = 2'd2;
    localparam logic [1:0] REG_STEP_HIGH = 2'd3;

    // Command codes.
    localparam logic [2:0] MODE_SET = 3'd0;
    localparam logic [2:0] MODE_STEP = 3'd1;
    localparam logic [2:0] MODE_SEEK_UP = 3'd2;
    localparam logic [2:0] MODE_SEEK_DN = 3'd3;
    localparam logic [2:0] MODE_STORE = 3'd4;
    localparam logic [2:0] MODE_LOAD = 3'd5;

    // Table port requests from the sequencer.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [15:0]      wr_data;
    } tbl_req_t;

    // Clamp a signed wide value into the band; band_min wins on conflict.
    function automatic logic [15:0] clamp_band(input logic signed [18:0] f,
                                               input logic [15:0] bmin,
                                               input logic [15:0] bmax);
        logic signed [18:0] v;
        v = f;
        if (v > $signed({3'b000, bmax}))
        begin
            v = $signed({3'b000, bmax});
        end
        if (v < $signed({3'b000, bmin}))
        begin
            v = $signed({3'b000, bmin});
        end
        return v[15:0];
    endfunction

endpackage

### rtl/tfpt_table.sv
// Preset table memory with one write port and one registered read port.
module tfpt_table (
    input  logic                      clk,
    input  tfpt_pkg::tbl_req_t        req,
    output logic [15:0]               rd_data
);

    logic [15:0] mem [tfpt_pkg::PRESETS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

### rtl/tfpt_seq.sv
// Command sequencer: walks the preset table one entry per step.
module tfpt_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2:0]                   mode,
    input  logic [15:0]                  new_freq,
    input  logic signed [7:0]            step_mult,
    input  logic [5:0]                   slot,
    input  logic [15:0]                  band_min,
    input  logic [15:0]                  band_max,
    input  logic [7:0]                   step_low,
    input  logic [7:0]                   step_high,
    output logic                         busy,
    output logic                         done,
    output logic [15:0]                  res_freq,
    output logic [6:0]                   res_preset,
    output tfpt_pkg::tbl_req_t           tbl_req,
    input  logic [15:0]                  rd_data
);

    localparam int IW = tfpt_pkg::IDX_W;
    localparam int CW = tfpt_pkg::CNT_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_FIND  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] mode_reg;
    logic [15:0] freq_reg, freq_next;
    logic [15:0] found_reg, found_next;
    logic [15:0] carry_reg, carry_next;
    logic signed [18:0] prod_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wptr_reg, wptr_next;
    logic del_reg, del_next;
    logic pend_reg, pend_next;
    logic hit_reg, hit_next;
    logic [6:0] preset_reg, preset_next;
    logic signed [8:0] step_s;
    logic [CW-1:0] idx_prev;
    logic [15:0] c;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res_freq = freq_reg;
    assign res_preset = preset_reg;
    assign c = rd_data;
    assign idx_prev = idx_reg - CW'(1);

    // Step size chosen by the side of the split frequency.
    always_comb
    begin
        if (step_mult > 8'sd0)
        begin
            step_s = $signed({1'b0, (freq_reg >= tfpt_pkg::SPLIT_FREQ) ? step_high : step_low});
        end
        else
        begin
            step_s = $signed({1'b0, (freq_reg <= tfpt_pkg::SPLIT_FREQ) ? step_low : step_high});
        end
    end

    // Next-state and datapath logic.
    always_comb
    begin
        state_next = state_reg;
        freq_next = freq_reg;
        found_next = found_reg;
        carry_next = carry_reg;
        idx_next = idx_reg;
        wptr_next = wptr_reg;
        del_next = del_reg;
        pend_next = 1'b0;
        hit_next = hit_reg;
        preset_next = preset_reg;
        tbl_req = '0;
        case (state_reg)
            S_CLEAR:
            begin
                // Fill the table with the empty mark after reset.
                tbl_req.wr_en = 1'b1;
                tbl_req.wr_addr = idx_reg[IW-1:0];
                tbl_req.wr_data = tfpt_pkg::EMPTY_MARK;
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(tfpt_pkg::PRESETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    found_next = freq_reg;
                    hit_next = 1'b0;
                    case (mode)
                        tfpt_pkg::MODE_SET:
                        begin
                            freq_next = tfpt_pkg::clamp_band({3'b000, new_freq},
                                                             band_min, band_max);
                            state_next = S_FIND;
                        end
                        tfpt_pkg::MODE_STEP:
                        begin
                            state_next = S_MUL;
                        end
                        tfpt_pkg::MODE_SEEK_UP, tfpt_pkg::MODE_SEEK_DN,
                        tfpt_pkg::MODE_STORE:
                        begin
                            state_next = S_SCAN;
                        end
                        tfpt_pkg::MODE_LOAD:
                        begin
                            if (CW'(slot) < CW'(tfpt_pkg::PRESETS))
                            begin
                                tbl_req.rd_en = 1'b1;
                                tbl_req.rd_addr = IW'(slot);
                                pend_next = 1'b1;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIND;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                freq_next = tfpt_pkg::clamp_band($signed({3'b000, freq_reg}) + prod_reg,
                                                 band_min, band_max);
                state_next = S_FIND;
            end
            S_SCAN:
            begin
                // Reads are issued ahead through the registered read port; pend marks valid data.
                if (mode_reg == tfpt_pkg::MODE_LOAD)
                begin
                    if (c != tfpt_pkg::EMPTY_MARK)
                    begin
                        freq_next = tfpt_pkg::clamp_band({3'b000, c}, band_min, band_max);
                    end
                    idx_next = '0;
                    state_next = S_FIND;
                end
                else if (!pend_reg)
                begin
                    tbl_req.rd_en = 1'b1;
                    tbl_req.rd_addr = idx_reg[IW-1:0];
                    idx_next = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    case (mode_reg)
                        tfpt_pkg::MODE_SEEK_UP:
                        begin
                            if (c != tfpt_pkg::EMPTY_MARK && c > freq_reg)
                            begin
                                freq_next = tfpt_pkg::clamp_band({3'b000, c},
                                                                 band_min, band_max);
                                idx_next = '0;
                                state_next = S_FIND;
                            end
                        end
                        tfpt_pkg::MODE_SEEK_DN:
                        begin
                            if (c != tfpt_pkg::EMPTY_MARK)
                            begin
                                if (c < freq_reg)
                                begin
                                    found_next = c;
                                end
                                else
                                begin
                                    freq_next = tfpt_pkg::clamp_band({3'b000, found_reg},
                                                                     band_min, band_max);
                                    idx_next = '0;
                                    state_next = S_FIND;
                                end
                            end
                        end
                        default:
                        begin
                            // Store or delete: look for the first entry not below.
                            if (freq_reg == tfpt_pkg::EMPTY_MARK)
                            begin
                                idx_next = '0;
                                state_next = S_FIND;
                            end
                            else if (c >= freq_reg)
                            begin
                                del_next = (c == freq_reg);
                                wptr_next = idx_prev;
                                carry_next = freq_reg;
                                if (c == freq_reg)
                                begin
                                    state_next = S_SHIFT;
                                end
                                else
                                begin
                                    tbl_req.wr_en = 1'b1;
                                    tbl_req.wr_addr = idx_prev[IW-1:0];
                                    tbl_req.wr_data = freq_reg;
                                    carry_next = c;
                                    wptr_next = idx_reg;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                    endcase
                    if (state_next == S_SCAN)
                    begin
                        if (idx_reg == CW'(tfpt_pkg::PRESETS))
                        begin
                            if (mode_reg == tfpt_pkg::MODE_SEEK_UP)
                            begin
                                freq_next = tfpt_pkg::clamp_band({3'b000, freq_reg},
                                                                 band_min, band_max);
                            end
                            else if (mode_reg == tfpt_pkg::MODE_SEEK_DN)
                            begin
                                freq_next = tfpt_pkg::clamp_band({3'b000, found_next},
                                                                 band_min, band_max);
                            end
                            idx_next = '0;
                            state_next = S_FIND;
                        end
                        else
                        begin
                            tbl_req.rd_en = 1'b1;
                            tbl_req.rd_addr = idx_reg[IW-1:0];
                            idx_next = idx_reg + CW'(1);
                            pend_next = 1'b1;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                // Each entry is moved by a read, then a write.
                if (del_reg)
                begin
                    if (wptr_reg == CW'(tfpt_pkg::PRESETS - 1))
                    begin
                        tbl_req.wr_en = 1'b1;
                        tbl_req.wr_addr = wptr_reg[IW-1:0];
                        tbl_req.wr_data = tfpt_pkg::EMPTY_MARK;
                        idx_next = '0;
                        state_next = S_FIND;
                    end
                    else if (!pend_reg)
                    begin
                        tbl_req.rd_en = 1'b1;
                        tbl_req.rd_addr = IW'(wptr_reg + CW'(1));
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        tbl_req.wr_en = 1'b1;
                        tbl_req.wr_addr = wptr_reg[IW-1:0];
                        tbl_req.wr_data = c;
                        wptr_next = wptr_reg + CW'(1);
                    end
                end
                else
                begin
                    if (wptr_reg == CW'(tfpt_pkg::PRESETS))
                    begin
                        idx_next = '0;
                        state_next = S_FIND;
                    end
                    else if (!pend_reg)
                    begin
                        tbl_req.rd_en = 1'b1;
                        tbl_req.rd_addr = wptr_reg[IW-1:0];
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        tbl_req.wr_en = 1'b1;
                        tbl_req.wr_addr = wptr_reg[IW-1:0];
                        tbl_req.wr_data = carry_reg;
                        carry_next = c;
                        wptr_next = wptr_reg + CW'(1);
                    end
                end
            end
            S_FIND:
            begin
                // Locate the first stored copy of the final frequency.
                if (pend_reg && !hit_reg && c != tfpt_pkg::EMPTY_MARK && c == freq_reg)
                begin
                    hit_next = 1'b1;
                    preset_next = 7'(idx_reg);
                end
                if (idx_reg == CW'(tfpt_pkg::PRESETS) || (pend_reg && hit_next))
                begin
                    if (!hit_next)
                    begin
                        preset_next = '0;
                    end
                    if (!pend_reg || hit_next || idx_reg == CW'(tfpt_pkg::PRESETS))
                    begin
                        state_next = (pend_reg || idx_reg == '0 || hit_next) ?
                                     S_DONE : S_FIND;
                    end
                end
                if (state_next == S_FIND && idx_reg != CW'(tfpt_pkg::PRESETS))
                begin
                    tbl_req.rd_en = 1'b1;
                    tbl_req.rd_addr = idx_reg[IW-1:0];
                    idx_next = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (state_next == S_FIND)
                begin
                    pend_next = 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            freq_reg <= tfpt_pkg::BAND_MIN_RST;
            idx_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            freq_reg <= freq_next;
            idx_reg <= idx_next;
            pend_reg <= pend_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        carry_reg <= carry_next;
        wptr_reg <= wptr_next;
        del_reg <= del_next;
        hit_reg <= hit_next;
        preset_reg <= preset_next;
        if (state_reg == S_IDLE && start)
        begin
            mode_reg <= mode;
            prod_reg <= 19'(step_s * $signed({step_mult[7], step_mult}));
        end
    end

endmodule

### rtl/tuner_frequency_preset_table_core.sv
// Top level of the tuner frequency preset table.
//
// Usage: commands arrive on the in channel (mode, new_freq, step_mult, slot)
// with in_valid/in_ready. Each command yields exactly one item on the out
// channel (freq_now, preset_number) with out_valid/out_ready.
// Registers band_min, band_max, step_low and step_high are written through
// the cfg channel by index 0 to 3; the user must write them only while the
// block is idle, which the block itself does not enforce. One command is
// processed at a time; in_ready is low while it runs. A seek scans the
// table; a store or delete scans it, then moves entries with one read and
// one write per moved entry; every command ends with a preset lookup. All
// table reads go through the memory's single read port.
// The result is held in an output register; a new command is accepted only
// once the sequencer is idle and no result waits.
// After reset the table is cleared one entry per cycle, with in_ready low;
// configuration writes are taken meanwhile.
// A stalled receiver holds the result and blocks further commands.
module tuner_frequency_preset_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [15:0] new_freq,
    input  logic signed [7:0] step_mult,
    input  logic [5:0]  slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] freq_now,
    output logic [6:0]  preset_number,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] band_min_reg, band_max_reg;
    logic [7:0] step_low_reg, step_high_reg;
    logic busy, done, start;
    logic [15:0] res_freq, rd_data;
    logic [6:0] res_preset;
    tfpt_pkg::tbl_req_t tbl_req;

    assign cfg_ready = 1'b1;
    assign in_ready = !busy && !(out_valid && !out_ready);
    assign start = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_min_reg <= tfpt_pkg::BAND_MIN_RST;
            band_max_reg <= tfpt_pkg::BAND_MAX_RST;
            step_low_reg <= tfpt_pkg::STEP_RST;
            step_high_reg <= tfpt_pkg::STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tfpt_pkg::REG_BAND_MIN:  band_min_reg <= cfg_data;
                tfpt_pkg::REG_BAND_MAX:  band_max_reg <= cfg_data;
                tfpt_pkg::REG_STEP_LOW:  step_low_reg <= cfg_data[7:0];
                tfpt_pkg::REG_STEP_HIGH: step_high_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tfpt_seq u_seq (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode),
        .new_freq(new_freq), .step_mult(step_mult), .slot(slot),
        .band_min(band_min_reg), .band_max(band_max_reg),
        .step_low(step_low_reg), .step_high(step_high_reg),
        .busy(busy), .done(done), .res_freq(res_freq), .res_preset(res_preset),
        .tbl_req(tbl_req), .rd_data(rd_data)
    );

    tfpt_table u_table (.clk(clk), .req(tbl_req), .rd_data(rd_data));

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (done)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            freq_now <= res_freq;
            preset_number <= res_preset;
        end
    end

`ifndef NO_ASSERTIONS
    // No command is taken while the sequencer runs.
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("in_ready high while busy");
    // A finished command never overwrites an untaken result.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(out_valid && !out_ready)) else $error("result overrun");
    // Result stays put while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(freq_now))
        else $error("result changed while stalled");
`endif

endmodule
